FILE: sv/indexed_sequence_store_core_defines.svh
// Assertion macros for the verification files of the indexed sequence store.
// Depends on nothing; included by the checker module.
`ifndef INDEXED_SEQUENCE_STORE_CORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ISQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: sv/isq_pkg.sv
// Types and constants of the indexed sequence store.
// Depends on nothing; used by the interfaces, the cell, the top level and the checker.
package isq_pkg;

	localparam int WORD_W = 32;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 5;
	localparam int CNT_W  = 5;

	typedef logic signed [WORD_W-1:0] word_t;

	// Command codes as they arrive on the command channel.
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_READ_AT    = 3'd4,
		CMD_INSERT_AT  = 3'd5,
		CMD_REMOVE_AT  = 3'd6
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Shift operation broadcast along the cell row.
	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_OPEN  = 2'd1,
		OP_CLOSE = 2'd2
	} shift_op_t;

	// Control word shared by every cell of the row.
	typedef struct packed {
		shift_op_t op;
		word_t     word;
	} cell_ctl_t;

	localparam word_t MISS_WORD = -32'sd1;

endpackage

FILE: sv/isq_cmd_if.sv
// Command channel of the indexed sequence store: valid/ready plus one command word.
// Depends on isq_pkg.
interface isq_cmd_if;
	import isq_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [POS_W-1:0]   position;
	word_t              data_in;

	modport source (output valid, output cmd, output position, output data_in, input ready);
	modport sink   (input valid, input cmd, input position, input data_in, output ready);
endinterface

FILE: sv/isq_rsp_if.sv
// Response channel of the indexed sequence store: valid/ready plus one result word.
// Depends on isq_pkg.
interface isq_rsp_if;
	import isq_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	word_t            data_out;
	logic [CNT_W-1:0] count;

	modport source (output valid, output status, output data_out, output count, input ready);
	modport sink   (input valid, input status, input data_out, input count, output ready);
endinterface

FILE: sv/indexed_sequence_store_core.sv
// Top level of the indexed sequence store: command decode, occupancy and result register.
// Depends on isq_pkg, isq_cmd_if, isq_rsp_if and isq_cell.
//
//   channel | dir | word contents                  | accepted when
//   req     | in  | cmd, position, data_in         | req.valid && req.ready
//   rsp     | out | status, data_out, count        | rsp.valid && rsp.ready
//
// For every command, the row of DEPTH cells shifts, writes or
// reads in the cycle the command word is accepted, and the result is in the
// output register on the next cycle. One command per cycle is sustained while
// rsp.ready stays high; a stalled result holds req.ready low until it is taken.
// Reset clears the occupancy and the result valid; element contents are not reset.
module indexed_sequence_store_core #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	isq_cmd_if.sink    req,
	isq_rsp_if.source  rsp
);
	import isq_pkg::*;

	localparam int OW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int CW = (OW > POS_W) ? OW : POS_W;

	logic [OW-1:0]    occ_q;
	logic [OW-1:0]    occ_nxt;
	logic [CW-1:0]    pos_w;
	logic [CW-1:0]    occ_w;
	logic [IW-1:0]    tgt;
	logic             full;
	logic             accept;
	shift_op_t        op;
	cell_ctl_t        ctl;
	status_t          status_nxt;
	word_t            data_nxt;
	word_t            rd_word;
	word_t            cell_word [DEPTH];
	word_t            sel_word  [DEPTH];

	logic             rsp_valid_q;
	status_t          status_q;
	word_t            data_q;
	logic [CNT_W-1:0] count_q;

	// A new command is taken whenever the result register is free or being drained.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign pos_w = CW'(req.position);
	assign occ_w = CW'(occ_q);
	assign full  = (occ_q == OW'(DEPTH));

	// Read bus: the addressed cell drives its word, all others drive zero.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | sel_word[i];
		end
	end

	// Command decode: target slot, shift operation, status, data and new count.
	always_comb begin
		tgt        = '0;
		op         = OP_HOLD;
		status_nxt = ST_DONE;
		data_nxt   = '0;
		occ_nxt    = occ_q;
		case (req.cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
				if (req.cmd == CMD_PUSH_BACK) begin
					tgt = IW'(occ_q);
				end else if (req.cmd == CMD_INSERT_AT) begin
					tgt = IW'(pos_w);
				end
				if (full) begin
					status_nxt = ST_FULL;
				end else if (req.cmd == CMD_INSERT_AT && pos_w > occ_w) begin
					status_nxt = ST_RANGE;
				end else begin
					op      = OP_OPEN;
					occ_nxt = occ_q + OW'(1);
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (occ_q == '0) begin
					status_nxt = ST_RANGE;
				end else begin
					if (req.cmd == CMD_POP_BACK) begin
						tgt = IW'(occ_q - OW'(1));
					end
					op       = OP_CLOSE;
					data_nxt = rd_word;
					occ_nxt  = occ_q - OW'(1);
				end
			end
			CMD_READ_AT: begin
				if (pos_w < occ_w) begin
					tgt      = IW'(pos_w);
					data_nxt = rd_word;
				end else begin
					status_nxt = ST_RANGE;
					data_nxt   = MISS_WORD;
				end
			end
			CMD_REMOVE_AT: begin
				if (pos_w < occ_w) begin
					tgt     = IW'(pos_w);
					op      = OP_CLOSE;
					occ_nxt = occ_q - OW'(1);
				end else begin
					status_nxt = ST_RANGE;
				end
			end
			default: begin
				status_nxt = ST_RANGE;
			end
		endcase
	end

	assign ctl = '{op: (accept ? op : OP_HOLD), word: req.data_in};

	// Row of cells; each one sees its lower and upper neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_w;
		word_t right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_inner_l
			assign left_w = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_word[i];
		end else begin : g_inner_r
			assign right_w = cell_word[i+1];
		end

		isq_cell #(
			.IW (IW)
		) u_cell (
			.clk        (clk),
			.idx        (IW'(i)),
			.tgt        (tgt),
			.ctl        (ctl),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i]),
			.sel_word   (sel_word[i])
		);
	end

	// Occupancy and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q       <= occ_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			data_q   <= data_nxt;
			count_q  <= CNT_W'(occ_nxt);
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = status_q;
	assign rsp.data_out = data_q;
	assign rsp.count    = count_q;

endmodule

FILE: sv/isq_cell.sv
// One storage cell of the shifting row: holds one element and trades it with its neighbors.
// Depends on isq_pkg.
module isq_cell #(
	parameter int IW = 4
) (
	input  logic              clk,
	input  logic [IW-1:0]     idx,
	input  logic [IW-1:0]     tgt,
	input  isq_pkg::cell_ctl_t ctl,
	input  isq_pkg::word_t    left_word,
	input  isq_pkg::word_t    right_word,
	output isq_pkg::word_t    word,
	output isq_pkg::word_t    sel_word
);
	import isq_pkg::*;

	word_t word_q;

	// Opening a gap moves words up from the target; closing one moves them down onto it.
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_OPEN: begin
				if (idx > tgt) begin
					word_q <= left_word;
				end else if (idx == tgt) begin
					word_q <= ctl.word;
				end
			end
			OP_CLOSE: begin
				if (idx >= tgt) begin
					word_q <= right_word;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	assign word = word_q;

	// Only the addressed cell puts its word on the read bus.
	assign sel_word = (idx == tgt) ? word_q : '0;

endmodule

FILE: sv/isq_chk.sv
// Port-level checker of the indexed sequence store and its bind to the top level.
// Depends on isq_pkg and indexed_sequence_store_core_defines.svh.
`include "indexed_sequence_store_core_defines.svh"

module isq_chk #(
	parameter int DEPTH = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [1:0]             rsp_status,
	input isq_pkg::word_t         rsp_data,
	input logic [isq_pkg::CNT_W-1:0] rsp_count
);
	import isq_pkg::*;

	// Every accepted command yields a result word in the next cycle.
	`ISQ_ASSERT_NEXT(a_accept_gives_rsp, clk, arst_n, req_valid && req_ready, rsp_valid, "accepted command produced no result")

	// With no result pending the block must take commands.
	`ISQ_ASSERT_NOW(a_ready_when_free, clk, arst_n, !rsp_valid, req_ready, "block stalled with empty result register")

	// A full report only comes from a store that holds DEPTH elements.
	`ISQ_ASSERT_NOW(a_full_count, clk, arst_n, rsp_valid && rsp_status == ST_FULL, rsp_count == CNT_W'(DEPTH), "full status with wrong count")

	// A stalled result word stays put.
	`ISQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_data) && $stable(rsp_count), "stalled result changed")

endmodule

bind indexed_sequence_store_core isq_chk #(
	.DEPTH (DEPTH)
) u_isq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_data   (rsp.data_out),
	.rsp_count  (rsp.count)
);
